FILE: rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // Record queue sizing: room for two records per byte plus two already waiting.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_BLOCKED = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_LEAD    = 3'd1,
        PH_INT     = 3'd2,
        PH_FRAC    = 3'd3,
        PH_EXP     = 3'd4,
        PH_EXPSIGN = 3'd5,
        PH_EXPDIG  = 3'd6,
        PH_NONE    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_NUMBER  = 3'd1,
        KIND_STRING  = 3'd2,
        KIND_OPEN    = 3'd3,
        KIND_CLOSE   = 3'd4,
        KIND_ERROR   = 3'd5,
        KIND_UNTERM  = 3'd6,
        KIND_END     = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [LENGTH_BITS-1:0]  length;
        logic [LINE_BITS-1:0]    line;
        logic [COLUMN_BITS-1:0]  column;
        logic                    text_done;
        logic                    run_last;
    } record_t;

    typedef struct packed {
        logic [1:0] count;
        record_t    rec0;
        record_t    rec1;
    } push_t;

    typedef struct packed {
        phase_t phase;
        logic   point;
    } num_step_t;

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sign(logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_final(phase_t ph);
        return (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXPDIG);
    endfunction

    // Number automaton: next phase, PH_NONE when the byte cannot extend it.
    function automatic num_step_t number_next(phase_t ph, logic [7:0] c, logic pt);
        num_step_t r;
        logic      d;
        logic      e;
        d = is_digit(c);
        e = (c == CH_LOW_E) || (c == CH_UP_E);
        r.phase = PH_NONE;
        r.point = pt;
        case (ph)
            PH_START: begin
                if (is_sign(c)) begin
                    r.phase = PH_LEAD;
                end else if (c == CH_POINT) begin
                    r.phase = PH_LEAD;
                    r.point = 1'b1;
                end else if (d) begin
                    r.phase = PH_INT;
                end
            end
            PH_LEAD: begin
                if (d) r.phase = pt ? PH_FRAC : PH_INT;
            end
            PH_INT: begin
                if ((c == CH_POINT) && !pt) begin
                    r.phase = PH_FRAC;
                    r.point = 1'b1;
                end else if (d) begin
                    r.phase = PH_INT;
                end else if (e) begin
                    r.phase = PH_EXP;
                end
            end
            PH_FRAC: begin
                if (d) r.phase = PH_FRAC;
                else if (e) r.phase = PH_EXP;
            end
            PH_EXP: begin
                if (is_sign(c)) r.phase = PH_EXPSIGN;
                else if (d) r.phase = PH_EXPDIG;
            end
            PH_EXPSIGN, PH_EXPDIG: begin
                if (d) r.phase = PH_EXPDIG;
            end
            default: r.phase = PH_NONE;
        endcase
        return r;
    endfunction

    function automatic record_t make_record(kind_t k, logic [LENGTH_BITS-1:0] len,
                                            logic [LINE_BITS-1:0] ln,
                                            logic [COLUMN_BITS-1:0] col);
        record_t r;
        r.kind      = k;
        r.length    = len;
        r.line      = ln;
        r.column    = col;
        r.text_done = 1'b0;
        r.run_last  = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/stt_scan.sv
`default_nettype none

module stt_scan (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 end_of_text,
    output stt_pkg::push_t            push,
    output stt_pkg::mode_t            mode
);

    stt_pkg::mode_t                         mode_reg, mode_next;
    stt_pkg::phase_t                        phase_reg, phase_next;
    logic                                   point_reg, point_next;
    logic [stt_pkg::LENGTH_BITS-1:0]        len_reg, len_next, len_inc;
    logic [stt_pkg::LINE_BITS-1:0]          pline_reg, pline_next;
    logic [stt_pkg::COLUMN_BITS-1:0]        pcol_reg, pcol_next;
    logic [stt_pkg::LINE_BITS-1:0]          cline_reg, cline_next;
    logic [stt_pkg::COLUMN_BITS-1:0]        ccol_reg, ccol_next;

    stt_pkg::num_step_t num_cont, num_first;
    stt_pkg::record_t   rec_a, rec_b, rec_c, flush_rec, out0, out1;
    logic               va, vb, vc, fv, rescan;
    logic [1:0]         cnt;

    assign len_inc = (len_reg == {stt_pkg::LENGTH_BITS{1'b1}}) ? len_reg
                     : len_reg + stt_pkg::LENGTH_BITS'(1);
    assign num_cont  = stt_pkg::number_next(phase_reg, text_byte, point_reg);
    assign num_first = stt_pkg::number_next(stt_pkg::PH_START, text_byte, 1'b0);

    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        point_next = point_reg;
        len_next   = len_reg;
        pline_next = pline_reg;
        pcol_next  = pcol_reg;
        rescan     = 1'b0;
        va         = 1'b0;
        vb         = 1'b0;
        fv         = 1'b0;
        rec_a      = '0;
        rec_b      = '0;
        flush_rec  = '0;

        // Close out or extend the token in progress
        case (mode_reg)
            stt_pkg::MODE_IDLE: rescan = 1'b1;
            stt_pkg::MODE_IDENT: begin
                if (stt_pkg::is_letter(text_byte)) begin
                    len_next = len_inc;
                end else begin
                    va     = 1'b1;
                    rec_a  = stt_pkg::make_record(stt_pkg::KIND_IDENT, len_reg,
                                                  pline_reg, pcol_reg);
                    mode_next = stt_pkg::MODE_IDLE;
                    rescan = 1'b1;
                end
            end
            stt_pkg::MODE_STRING: begin
                if (text_byte == stt_pkg::CH_QUOTE) begin
                    va    = 1'b1;
                    rec_a = stt_pkg::make_record(stt_pkg::KIND_STRING, len_reg,
                                                 pline_reg, pcol_reg);
                    mode_next = stt_pkg::MODE_IDLE;
                end else begin
                    len_next = len_inc;
                end
            end
            stt_pkg::MODE_NUMBER: begin
                if (num_cont.phase != stt_pkg::PH_NONE) begin
                    phase_next = num_cont.phase;
                    point_next = num_cont.point;
                    len_next   = len_inc;
                end else if (stt_pkg::is_final(phase_reg)) begin
                    va    = 1'b1;
                    rec_a = stt_pkg::make_record(stt_pkg::KIND_NUMBER, len_reg,
                                                 pline_reg, pcol_reg);
                    mode_next = stt_pkg::MODE_IDLE;
                    rescan = 1'b1;
                end else begin
                    va    = 1'b1;
                    rec_a = stt_pkg::make_record(stt_pkg::KIND_ERROR, '0,
                                                 cline_reg, ccol_reg);
                    mode_next = stt_pkg::MODE_BLOCKED;
                end
            end
            stt_pkg::MODE_COMMENT: begin
                if (text_byte == stt_pkg::CH_LF) mode_next = stt_pkg::MODE_IDLE;
            end
            default: mode_next = stt_pkg::MODE_BLOCKED;
        endcase

        // Scan the byte as the start of what follows
        if (rescan) begin
            if (stt_pkg::is_blank(text_byte)) begin
                mode_next = stt_pkg::MODE_IDLE;
            end else if (text_byte == stt_pkg::CH_HASH) begin
                mode_next  = stt_pkg::MODE_COMMENT;
                len_next   = '0;
                pline_next = cline_reg;
                pcol_next  = ccol_reg;
            end else if (stt_pkg::is_letter(text_byte)) begin
                mode_next  = stt_pkg::MODE_IDENT;
                len_next   = stt_pkg::LENGTH_BITS'(1);
                pline_next = cline_reg;
                pcol_next  = ccol_reg;
            end else if (text_byte == stt_pkg::CH_QUOTE) begin
                mode_next  = stt_pkg::MODE_STRING;
                len_next   = '0;
                pline_next = cline_reg;
                pcol_next  = ccol_reg;
            end else if (num_first.phase != stt_pkg::PH_NONE) begin
                mode_next  = stt_pkg::MODE_NUMBER;
                phase_next = num_first.phase;
                point_next = num_first.point;
                len_next   = stt_pkg::LENGTH_BITS'(1);
                pline_next = cline_reg;
                pcol_next  = ccol_reg;
            end else if (text_byte == stt_pkg::CH_OPEN) begin
                vb    = 1'b1;
                rec_b = stt_pkg::make_record(stt_pkg::KIND_OPEN, stt_pkg::LENGTH_BITS'(1),
                                             cline_reg, ccol_reg);
            end else if (text_byte == stt_pkg::CH_CLOSE) begin
                vb    = 1'b1;
                rec_b = stt_pkg::make_record(stt_pkg::KIND_CLOSE, stt_pkg::LENGTH_BITS'(1),
                                             cline_reg, ccol_reg);
            end else begin
                vb    = 1'b1;
                rec_b = stt_pkg::make_record(stt_pkg::KIND_ERROR, '0, cline_reg, ccol_reg);
                mode_next = stt_pkg::MODE_BLOCKED;
            end
        end

        // Position counters
        if (text_byte == stt_pkg::CH_LF) begin
            cline_next = (cline_reg == {stt_pkg::LINE_BITS{1'b1}}) ? cline_reg
                         : cline_reg + stt_pkg::LINE_BITS'(1);
            ccol_next  = stt_pkg::COLUMN_BITS'(1);
        end else begin
            cline_next = cline_reg;
            ccol_next  = (ccol_reg == {stt_pkg::COLUMN_BITS{1'b1}}) ? ccol_reg
                         : ccol_reg + stt_pkg::COLUMN_BITS'(1);
        end

        // End-of-text flush of whatever is still open
        case (mode_next)
            stt_pkg::MODE_IDENT: begin
                fv        = 1'b1;
                flush_rec = stt_pkg::make_record(stt_pkg::KIND_IDENT, len_next,
                                                 pline_next, pcol_next);
            end
            stt_pkg::MODE_NUMBER: begin
                fv        = 1'b1;
                flush_rec = stt_pkg::is_final(phase_next)
                    ? stt_pkg::make_record(stt_pkg::KIND_NUMBER, len_next, pline_next, pcol_next)
                    : stt_pkg::make_record(stt_pkg::KIND_ERROR, '0, cline_next, ccol_next);
            end
            stt_pkg::MODE_STRING: begin
                fv        = 1'b1;
                flush_rec = stt_pkg::make_record(stt_pkg::KIND_UNTERM, len_next,
                                                 pline_next, pcol_next);
            end
            stt_pkg::MODE_COMMENT: begin
                fv        = 1'b1;
                flush_rec = stt_pkg::make_record(stt_pkg::KIND_UNTERM, '0,
                                                 pline_next, pcol_next);
            end
            default: fv = 1'b0;
        endcase

        rec_c = fv ? flush_rec
                   : stt_pkg::make_record(stt_pkg::KIND_END, '0, cline_reg, ccol_reg);
        vc    = end_of_text && (fv || !(va || vb));

        // Pack the candidates into at most two records
        out0 = va ? rec_a : (vb ? rec_b : rec_c);
        out1 = (va && vb) ? rec_b : rec_c;
        cnt  = 2'(({1'b0, va} + {1'b0, vb}) + {1'b0, vc});
        if (cnt > 2'd2) cnt = 2'd2;
        if (cnt == 2'd1) begin
            out0.run_last  = 1'b1;
            out0.text_done = end_of_text;
        end else if (cnt == 2'd2) begin
            out1.run_last  = 1'b1;
            out1.text_done = end_of_text;
        end

        if (end_of_text) begin
            mode_next  = stt_pkg::MODE_IDLE;
            phase_next = stt_pkg::PH_START;
            point_next = 1'b0;
            len_next   = '0;
            pline_next = stt_pkg::LINE_BITS'(1);
            pcol_next  = stt_pkg::COLUMN_BITS'(1);
            cline_next = stt_pkg::LINE_BITS'(1);
            ccol_next  = stt_pkg::COLUMN_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= stt_pkg::MODE_IDLE;
            phase_reg <= stt_pkg::PH_START;
            point_reg <= 1'b0;
            len_reg   <= '0;
            pline_reg <= stt_pkg::LINE_BITS'(1);
            pcol_reg  <= stt_pkg::COLUMN_BITS'(1);
            cline_reg <= stt_pkg::LINE_BITS'(1);
            ccol_reg  <= stt_pkg::COLUMN_BITS'(1);
        end else if (step) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            point_reg <= point_next;
            len_reg   <= len_next;
            pline_reg <= pline_next;
            pcol_reg  <= pcol_next;
            cline_reg <= cline_next;
            ccol_reg  <= ccol_next;
        end
    end

    assign push.count = step ? cnt : 2'd0;
    assign push.rec0  = out0;
    assign push.rec1  = out1;
    assign mode       = mode_reg;

endmodule

`default_nettype wire

FILE: rtl/stt_queue.sv
`default_nettype none

module stt_queue (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire stt_pkg::push_t                 push,
    input  wire logic                           pop,
    output stt_pkg::record_t                    head,
    output logic [stt_pkg::QCNT_BITS-1:0]       count
);

    stt_pkg::record_t                   q_mem [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_BITS-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [stt_pkg::QPTR_BITS-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [stt_pkg::QCNT_BITS-1:0]      count_reg, count_next;
    logic [stt_pkg::QPTR_BITS-1:0]      wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + stt_pkg::QPTR_BITS'(1);
    assign wr_ptr_next = wr_ptr_reg + stt_pkg::QPTR_BITS'(push.count);
    assign rd_ptr_next = rd_ptr_reg + stt_pkg::QPTR_BITS'(pop);
    assign count_next  = count_reg + stt_pkg::QCNT_BITS'(push.count)
                         - stt_pkg::QCNT_BITS'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) q_mem[wr_ptr_reg] <= push.rec0;
        if (push.count == 2'd2) q_mem[wr_ptr_inc] <= push.rec1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = q_mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: rtl/scene_text_tokenizer_unit.sv
// Flow: an accepted byte waits in the input register until the record queue has room,
//   is then scanned, and its records are written to the queue that drives m_tvalid.
// Throughput: one byte per cycle while the record queue holds at most two records;
//   input stalls at three or four; the m_ side drains one record per cycle on m_tready.
// Reset: synchronous, active low; clears the scanner to between-tokens at line 1,
//   column 1, and empties the input register and the record queue.
`default_nettype none

module scene_text_tokenizer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request in: one text byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    // request out: one token record
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [2:0] token_kind, [18:3] token_length,
                                        // [38:19] start_line, [54:39] start_column, [55] zero
    output logic             m_tuser,   // text_done
    output logic             m_tlast    // run_last
);

    // Input register: holds one byte until the queue can take its records
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        eot_reg;
    logic        step;
    logic        room;

    stt_pkg::push_t                     push;
    stt_pkg::mode_t                     mode;
    stt_pkg::record_t                   head;
    logic [stt_pkg::QCNT_BITS-1:0]      q_count;
    logic                               pop;

    // A byte may cause two records, so advance only with two free slots
    assign room     = (q_count <= stt_pkg::QCNT_BITS'(stt_pkg::QUEUE_DEPTH - 2));
    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: capture on every accepted request
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
    end

    // Scanner: mode, number automaton and position counters
    stt_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .text_byte   (byte_reg),
        .end_of_text (eot_reg),
        .push        (push),
        .mode        (mode)
    );

    // Record queue: absorb the occasional second record of a byte
    stt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .count   (q_count)
    );

    assign m_tvalid = (q_count != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {1'b0, head.column, head.line, head.length, head.kind};
    assign m_tuser  = head.text_done;
    assign m_tlast  = head.run_last;

    // The queue never holds more than its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= stt_pkg::QCNT_BITS'(stt_pkg::QUEUE_DEPTH))
        else $error("record queue overflow");

    // End of text always produces at least one record
    a_eot_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && eot_reg) |-> (push.count != 2'd0))
        else $error("end of text without record");

    // End of text returns the scanner to between tokens
    a_eot_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && eot_reg) |=> (mode == stt_pkg::MODE_IDLE))
        else $error("scanner not idle after end of text");

    // After an error nothing more is emitted until end of text
    a_blocked_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !eot_reg && (mode == stt_pkg::MODE_BLOCKED)) |-> (push.count == 2'd0))
        else $error("record emitted while blocked");

endmodule

`default_nettype wire
